// ===== rtl/hdc_pkg.sv =====
// Shared constants and helpers for the public holiday date classifier.
package hdc_pkg;

  localparam int unsigned DayW  = 5;
  localparam int unsigned MonW  = 4;
  localparam int unsigned YearW = 14;
  localparam int unsigned OffW  = 7;   // day offset from 1 March, covers March..June

  // Month codes
  localparam logic [MonW-1:0] MonJan = 4'd0;
  localparam logic [MonW-1:0] MonMar = 4'd2;
  localparam logic [MonW-1:0] MonApr = 4'd3;
  localparam logic [MonW-1:0] MonMay = 4'd4;
  localparam logic [MonW-1:0] MonJun = 4'd5;
  localparam logic [MonW-1:0] MonJul = 4'd6;
  localparam logic [MonW-1:0] MonAug = 4'd7;
  localparam logic [MonW-1:0] MonNov = 4'd10;
  localparam logic [MonW-1:0] MonDec = 4'd11;

  // First-day offsets of April, May, June from 1 March
  localparam logic [OffW-1:0] AprStart = 7'd31;
  localparam logic [OffW-1:0] MayStart = 7'd61;
  localparam logic [OffW-1:0] JunStart = 7'd92;

  // Movable feasts relative to Easter Monday
  localparam logic [OffW-1:0] AscensionOfs = 7'd38;
  localparam logic [OffW-1:0] WhitOfs      = 7'd49;

  // Computus constants
  localparam logic [15:0] Recip19   = 16'd55189;  // ceil(2^20 / 19)
  localparam logic [12:0] Recip100  = 13'd5243;   // ceil(2^19 / 100)
  localparam logic [5:0]  Recip25   = 6'd41;      // 2^10 / 25, rounded up
  localparam logic [7:0]  Recip3    = 8'd171;     // ceil(2^9 / 3)
  localparam logic [10:0] Recip30   = 11'd1093;   // ceil(2^15 / 30)
  localparam logic [8:0]  Recip7    = 9'd293;     // ceil(2^11 / 7)
  localparam logic [8:0]  EasterLim = 9'd451;
  // Easter Monday offset = h + l - 7m + 114 - 93 + 1
  localparam logic [OffW-1:0] MondayBase = 7'd22;

  // Fixed-date holidays
  function automatic logic fixed_hit(logic [DayW-1:0] day, logic [MonW-1:0] mon);
    logic hit;
    hit = 1'b0;
    case (mon)
      MonJan:  hit = (day == 5'd1);
      MonMay:  hit = (day == 5'd1) || (day == 5'd8);
      MonJul:  hit = (day == 5'd14);
      MonAug:  hit = (day == 5'd15);
      MonNov:  hit = (day == 5'd1) || (day == 5'd11);
      MonDec:  hit = (day == 5'd25);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== rtl/hdc_split.sv =====
// Year split stages: golden number, century and year-in-century, century terms.
module hdc_split (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [hdc_pkg::YearW-1:0]  year_i,
  output logic [4:0]                 a_o,
  output logic [7:0]                 b_o,
  output logic [4:0]                 i_o,
  output logic [1:0]                 k_o,
  output logic [1:0]                 e_o,
  output logic [2:0]                 f_o
);
  import hdc_pkg::*;

  logic [29:0] p19;
  logic [26:0] p100;
  logic [YearW-1:0] y_q;
  logic [9:0]  q19_q;
  logic [7:0]  q100_q;

  // stage 1: reciprocal multiplies, exact over the 14-bit year range
  assign p19  = 30'(year_i) * 30'(Recip19);
  assign p100 = 27'(year_i) * 27'(Recip100);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q    <= year_i;
      q19_q  <= p19[29:20];
      q100_q <= p100[26:19];
    end
  end

  // stage 2: remainders and (b + 8) / 25
  logic [13:0] m19, m100, a_full, c_full;
  logic [8:0]  bp8;
  logic [14:0] pf;
  logic [4:0]  a_q;
  logic [7:0]  b_q;
  logic [6:0]  c_q;
  logic [2:0]  f_q;

  assign m19    = 14'(q19_q) * 14'd19;
  assign m100   = 14'(q100_q) * 14'd100;
  assign a_full = y_q - m19;
  assign c_full = y_q - m100;
  assign bp8    = 9'(q100_q) + 9'd8;
  assign pf     = 15'(bp8) * 15'(Recip25);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_full[4:0];
      b_q <= q100_q;
      c_q <= c_full[6:0];
      f_q <= pf[12:10];
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign i_o = c_q[6:2];
  assign k_o = c_q[1:0];
  assign e_o = b_q[1:0];
  assign f_o = f_q;

endmodule

// ===== rtl/hdc_computus.sv =====
// Computus core stages: epact, weekday correction, Easter Monday offset.
module hdc_computus (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [4:0]                a_i,
  input  logic [7:0]                b_i,
  input  logic [4:0]                i_i,
  input  logic [1:0]                k_i,
  input  logic [1:0]                e_i,
  input  logic [2:0]                f_i,
  output logic [hdc_pkg::OffW-1:0]  mon_off_o
);
  import hdc_pkg::*;

  // stage 3: g and the sums that do not need it
  logic [5:0]  d;
  logic [9:0]  s1;
  logic [7:0]  gx;
  logic [15:0] pg;
  logic [6:0]  p;
  logic [9:0]  s1_q;
  logic [5:0]  g_q;
  logic [4:0]  a3_q;
  logic [6:0]  p3_q;

  assign d  = b_i[7:2];
  assign s1 = 10'(a_i) * 10'd19 + 10'(b_i) - 10'(d) + 10'd15;
  assign gx = b_i - 8'(f_i) + 8'd1;
  assign pg = 16'(gx) * 16'(Recip3);
  assign p  = 7'd32 + (7'(e_i) << 1) + (7'(i_i) << 1) - 7'(k_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1;
      g_q  <= pg[14:9];
      a3_q <= a_i;
      p3_q <= p;
    end
  end

  // stage 4: quotient of the epact sum by 30
  logic [9:0]  x;
  logic [20:0] pq;
  logic [9:0]  x_q;
  logic [4:0]  qh_q;
  logic [4:0]  a4_q;
  logic [6:0]  p4_q;

  assign x  = s1_q - 10'(g_q);
  assign pq = 21'(x) * 21'(Recip30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x;
      qh_q <= pq[19:15];
      a4_q <= a3_q;
      p4_q <= p3_q;
    end
  end

  // stage 5: h, then the weekday sum and its quotient by 7
  logic [9:0]  m30, hx;
  logic [4:0]  h;
  logic [6:0]  lsum;
  logic [15:0] pl;
  logic [4:0]  h_q;
  logic [6:0]  ls_q;
  logic [3:0]  ql_q;
  logic [4:0]  a5_q;

  assign m30  = 10'(qh_q) * 10'd30;
  assign hx   = x_q - m30;
  assign h    = hx[4:0];
  assign lsum = p4_q - 7'(h);
  assign pl   = 16'(lsum) * 16'(Recip7);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q  <= h;
      ls_q <= lsum;
      ql_q <= pl[14:11];
      a5_q <= a4_q;
    end
  end

  // stage 6: l, the late-April correction and the Easter Monday offset
  logic [6:0] lx;
  logic [2:0] l;
  logic [8:0] ms;
  logic       m;
  logic [6:0] mo_q;

  assign lx = ls_q - 7'(ql_q) * 7'd7;
  assign l  = lx[2:0];
  assign ms = 9'(a5_q) + 9'(h_q) * 9'd11 + 9'(l) * 9'd22;
  assign m  = (ms >= EasterLim);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mo_q <= 7'(h_q) + 7'(l) + MondayBase - (m ? 7'd7 : 7'd0);
    end
  end

  assign mon_off_o = mo_q;

endmodule

// ===== rtl/public_holiday_date_classifier.sv =====
// Top level of the public holiday date classifier pipeline.
// Classifies one Gregorian date per transaction as a French public holiday
// (eight fixed dates plus Easter Monday, Ascension and Whit Monday). The
// pipeline is seven register stages deep: two split the year by 19 and 100,
// four run the computus to an Easter Monday offset from 1 March, and the last
// compares that offset, plus 38 and 49 days, with the input date's own offset
// and drives the output register. A new date is taken every cycle unless stall_o
// is high, so the throughput is one transaction per cycle while nothing stalls.
// A stall on the output while a result is held there freezes the whole
// pipeline and is passed straight back to the input as stall_o. The block
// keeps no state between transactions; impossible dates are evaluated like
// any other and never match.
module public_holiday_date_classifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [hdc_pkg::DayW-1:0]   day_of_month_i,
  input  logic [hdc_pkg::MonW-1:0]   month_index_i,
  input  logic [hdc_pkg::YearW-1:0]  year_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic                       is_holiday_o
);
  import hdc_pkg::*;

  localparam int unsigned SideDepth = 6;  // stages from input to the offset result

  typedef struct packed {
    logic            fixed;    // fixed-date holiday
    logic            spring;   // date lies in March..June and is a real day, or is 31 June
    logic [OffW-1:0] off;      // date as an offset from 1 March
  } side_t;

  logic en;
  logic out_vld_q;
  logic hit_q;

  // Global stage enable: everything moves unless a finished result is held.
  assign en      = !(out_vld_q && stall_i);
  assign stall_o = !en;

  // Date-side terms, computed at the input and carried alongside the computus
  side_t           side_d;
  logic [OffW-1:0] start;
  logic            day_ok;

  always_comb begin
    start  = '0;
    day_ok = 1'b0;
    case (month_index_i)
      MonMar: begin
        start  = '0;
        day_ok = (day_of_month_i != '0);
      end
      MonApr: begin
        start  = AprStart;
        day_ok = (day_of_month_i != '0) && (day_of_month_i <= 5'd30);
      end
      MonMay: begin
        start  = MayStart;
        day_ok = (day_of_month_i != '0);
      end
      MonJun: begin
        // last month of the walk: no upper bound on the day
        start  = JunStart;
        day_ok = (day_of_month_i != '0);
      end
      default: begin
        start  = '0;
        day_ok = 1'b0;
      end
    endcase
    side_d.fixed  = fixed_hit(day_of_month_i, month_index_i);
    side_d.spring = day_ok;
    side_d.off    = 7'(day_of_month_i) - 7'd1 + start;
  end

  side_t side_q [SideDepth];
  logic [SideDepth-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int s = 1; s < SideDepth; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[SideDepth-2:0], valid_i};
      out_vld_q <= vld_q[SideDepth-1];
    end
  end

  // Computus datapath
  logic [4:0] a, ii;
  logic [7:0] b;
  logic [1:0] k, e;
  logic [2:0] f;
  logic [OffW-1:0] mon_off;

  hdc_split u_split (
    .clk_i  (clk_i),
    .en_i   (en),
    .year_i (year_i),
    .a_o    (a),
    .b_o    (b),
    .i_o    (ii),
    .k_o    (k),
    .e_o    (e),
    .f_o    (f)
  );

  hdc_computus u_computus (
    .clk_i     (clk_i),
    .en_i      (en),
    .a_i       (a),
    .b_i       (b),
    .i_i       (ii),
    .k_i       (k),
    .e_i       (e),
    .f_i       (f),
    .mon_off_o (mon_off)
  );

  // Final stage: match against Easter Monday, Ascension, Whit Monday and the fixed dates
  side_t side_l;
  logic  movable_hit;

  assign side_l      = side_q[SideDepth-1];
  assign movable_hit = side_l.spring &&
                       ((side_l.off == mon_off) ||
                        (side_l.off == mon_off + AscensionOfs) ||
                        (side_l.off == mon_off + WhitOfs));

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= side_l.fixed || movable_hit;
    end
  end

  assign valid_o      = out_vld_q;
  assign is_holiday_o = hit_q;

endmodule

// ===== rtl/hdc_checker.sv =====
// Port-level checker for the holiday classifier, bound to the top level.
module hdc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       valid_i,
  input logic                       stall_o,
  input logic [hdc_pkg::DayW-1:0]   day_of_month_i,
  input logic [hdc_pkg::MonW-1:0]   month_index_i,
  input logic [hdc_pkg::YearW-1:0]  year_i,
  input logic                       valid_o,
  input logic                       stall_i,
  input logic                       is_holiday_o
);

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(is_holiday_o))
    else $error("held result changed");

  // Backpressure only while a result is waiting on a stalled output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output backpressure");

  // A waiting result never blocks the input when the output side is free
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_i |-> !stall_o)
    else $error("input stalled while output is free");

  // Nothing comes out during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !valid_o)
    else $error("result valid during reset");

endmodule

bind public_holiday_date_classifier hdc_checker u_hdc_checker (.*);

// ===== test/tb_public_holiday_date_classifier.sv =====
// Self-checking testbench for the public holiday date classifier pipeline.
`timescale 1ns / 1ps

module tb_public_holiday_date_classifier;
  import hdc_pkg::*;

  localparam int TimeoutCycles = 200000;
  localparam int LongHold      = 60;   // cycles of forced output stall
  localparam int DrainCycles   = 20;   // exceeds the pipeline latency

  typedef struct packed {
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  mon;
    logic [YearW-1:0] yr;
  } date_t;

  typedef struct {
    date_t date;
    logic  holiday;
  } verdict_t;

  // Easter-based holidays, counted from Easter Monday
  typedef enum int {EasterMonday, Ascension, WhitMonday} feast_e;

  logic             clk_i;
  logic             rst_ni;
  logic             valid_i        = 1'b0;
  logic             stall_o;
  logic [DayW-1:0]  day_of_month_i = '0;
  logic [MonW-1:0]  month_index_i  = '0;
  logic [YearW-1:0] year_i         = '0;
  logic             valid_o;
  logic             stall_i        = 1'b0;
  logic             is_holiday_o;

  date_t    date_q[$];     // dates waiting to be offered
  verdict_t verdict_q[$];  // verdicts owed by the block, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req_seq   = 0;  // bumped by the stimulus to ask for a long output hold
  int hold_seen;
  int hold_left;
  int errors   = 0;
  int results  = 0;
  int holidays = 0;
  int cycles   = 0;

  date_t    acc_date;
  date_t    next_date;
  verdict_t acc_verdict;
  verdict_t oldest;

  public_holiday_date_classifier u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .day_of_month_i (day_of_month_i),
    .month_index_i  (month_index_i),
    .year_i         (year_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .is_holiday_o   (is_holiday_o)
  );

  // ---------------------------------------------------------------------------
  // Calendar arithmetic
  // ---------------------------------------------------------------------------

  // Easter Monday as a day offset from 1 March (anonymous Gregorian computus).
  // All intermediates stay non-negative for any 14-bit year, year 0 included.
  function automatic int easter_monday_ofs(input logic [YearW-1:0] yr);
    int y, a, b, c, d, e, f, g, h, i, k, l, m, t, emon, eday, sunday;
    y = int'(yr);
    a = y % 19;
    b = y / 100;
    c = y % 100;
    d = b / 4;
    e = b % 4;
    f = (b + 8) / 25;
    g = (b - f + 1) / 3;
    h = (19 * a + b - d - g + 15) % 30;
    i = c / 4;
    k = c % 4;
    l = (32 + 2 * e + 2 * i - h - k) % 7;
    m = (a + 11 * h + 22 * l) / 451;
    t = h + l - 7 * m + 114;
    emon = t / 31;               // 3 = March, 4 = April
    eday = (t % 31) + 1;
    sunday = (emon == 3) ? (eday - 1) : (31 + eday - 1);
    return sunday + 1;
  endfunction

  // Turn a March-based offset back into a date; never crosses into July here.
  function automatic date_t spring_date(input int ofs, input logic [YearW-1:0] yr);
    date_t dt;
    dt.yr = yr;
    if (ofs >= int'(JunStart)) begin
      dt.mon = MonJun;
      dt.day = DayW'(ofs - int'(JunStart) + 1);
    end else if (ofs >= int'(MayStart)) begin
      dt.mon = MonMay;
      dt.day = DayW'(ofs - int'(MayStart) + 1);
    end else if (ofs >= int'(AprStart)) begin
      dt.mon = MonApr;
      dt.day = DayW'(ofs - int'(AprStart) + 1);
    end else begin
      dt.mon = MonMar;
      dt.day = DayW'(ofs + 1);
    end
    return dt;
  endfunction

  // Movable feast of a year, optionally nudged by a few days for near misses.
  function automatic date_t movable_feast(input logic [YearW-1:0] yr, input feast_e which,
                                          input int nudge);
    int ofs;
    ofs = easter_monday_ofs(yr) + nudge;
    case (which)
      Ascension:  ofs += int'(AscensionOfs);
      WhitMonday: ofs += int'(WhitOfs);
      default:    ofs += 0;
    endcase
    return spring_date(ofs, yr);
  endfunction

  // The eight fixed-date holidays; year is left at zero.
  function automatic date_t fixed_holiday(input int idx);
    date_t dt;
    dt = '0;
    case (idx)
      0:       begin dt.day = 5'd1;  dt.mon = MonJan; end
      1:       begin dt.day = 5'd1;  dt.mon = MonMay; end
      2:       begin dt.day = 5'd8;  dt.mon = MonMay; end
      3:       begin dt.day = 5'd14; dt.mon = MonJul; end
      4:       begin dt.day = 5'd15; dt.mon = MonAug; end
      5:       begin dt.day = 5'd1;  dt.mon = MonNov; end
      6:       begin dt.day = 5'd11; dt.mon = MonNov; end
      default: begin dt.day = 5'd25; dt.mon = MonDec; end
    endcase
    return dt;
  endfunction

  // Expected classification: day and month must both match a holiday, so
  // impossible dates (day 0, day past month end, month 12..15) never hit.
  function automatic logic classify_date(input date_t dt);
    logic  hit;
    date_t feast;
    hit = 1'b0;
    for (int n = 0; n < 8; n++) begin
      feast = fixed_holiday(n);
      if (feast.day == dt.day && feast.mon == dt.mon) hit = 1'b1;
    end
    for (int j = 0; j < 3; j++) begin
      feast = movable_feast(dt.yr, feast_e'(j), 0);
      if (feast.day == dt.day && feast.mon == dt.mon) hit = 1'b1;
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_date(input int day, input int mon, input int yr);
    date_t dt;
    dt.day = DayW'(day);
    dt.mon = MonW'(mon);
    dt.yr  = YearW'(yr);
    date_q.push_back(dt);
  endtask

  // Mostly well-formed dates aimed at holidays and their neighbors, the rest
  // ordinary dates and full-width noise.
  task automatic queue_random_dates(input int count);
    date_t dt;
    int    pick;
    logic [YearW-1:0] yr;
    for (int n = 0; n < count; n++) begin
      yr = ($urandom_range(0, 4) == 0) ? YearW'($urandom_range(0, 16383))
                                       : YearW'($urandom_range(1583, 9999));
      pick = $urandom_range(0, 9);
      if (pick <= 1) begin
        dt = fixed_holiday($urandom_range(0, 7));
        dt.yr = yr;
      end else if (pick <= 4) begin
        dt = movable_feast(yr, feast_e'($urandom_range(0, 2)), 0);
      end else if (pick == 5) begin
        // one day either side of a movable feast
        dt = movable_feast(yr, feast_e'($urandom_range(0, 2)),
                           ($urandom_range(0, 1) == 0) ? -1 : 1);
      end else if (pick <= 7) begin
        dt.day = DayW'($urandom_range(1, 31));
        dt.mon = MonW'($urandom_range(0, 11));
        dt.yr  = yr;
      end else begin
        dt.day = DayW'($urandom_range(0, 31));
        dt.mon = MonW'($urandom_range(0, 15));
        dt.yr  = YearW'($urandom_range(0, 16383));
      end
      date_q.push_back(dt);
    end
  endtask

  // Sender pauses until every owed verdict has come back.
  task automatic drain();
    while (date_q.size() != 0 || valid_i || verdict_q.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == TimeoutCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued dates; a stalled transaction holds its payload.
  // The verdict is predicted when the transaction is accepted.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i        <= 1'b0;
      day_of_month_i <= '0;
      month_index_i  <= '0;
      year_i         <= '0;
    end else begin
      if (valid_i && !stall_o) begin
        acc_date.day        = day_of_month_i;
        acc_date.mon        = month_index_i;
        acc_date.yr         = year_i;
        acc_verdict.date    = acc_date;
        acc_verdict.holiday = classify_date(acc_date);
        verdict_q.push_back(acc_verdict);
      end
      // free to change only when nothing is offered or the offer just went in
      if (!valid_i || !stall_o) begin
        if (date_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_date = date_q.pop_front();
          day_of_month_i <= next_date.day;
          month_index_i  <= next_date.mon;
          year_i         <= next_date.yr;
          valid_i        <= 1'b1;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest owed verdict and
  // drives stall_i, including the long hold requested by the stimulus.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i   <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else begin
      if (valid_o && !stall_i) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual is_holiday=%0b",
                   $time, is_holiday_o);
        end else begin
          oldest = verdict_q.pop_front();
          results++;
          if (oldest.holiday) holidays++;
          if (is_holiday_o !== oldest.holiday) begin
            errors++;
            $display({"%0t: is_holiday mismatch for day %0d month %0d year %0d: ",
                      "expected %0b, actual %0b"},
                     $time, oldest.date.day, oldest.date.mon, oldest.date.yr,
                     oldest.holiday, is_holiday_o);
          end
        end
      end
      if (hold_seen != hold_req_seq) begin
        hold_seen <= hold_req_seq;
        hold_left <= LongHold - 1;
        stall_i   <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        stall_i   <= 1'b1;
      end else begin
        stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    date_t dt;
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: all fixed holidays, movable feasts in March/April/May/June,
    // Easter Sunday (not a holiday), field extremes and impossible dates.
    for (int n = 0; n < 8; n++) begin
      dt = fixed_holiday(n);
      queue_date(int'(dt.day), int'(dt.mon), 2024);
    end
    for (int j = 0; j < 3; j++) date_q.push_back(movable_feast(14'd2024, feast_e'(j), 0));
    date_q.push_back(movable_feast(14'd2285, EasterMonday, 0));   // earliest Easter
    date_q.push_back(movable_feast(14'd2038, WhitMonday, 0));     // latest Easter, June
    date_q.push_back(movable_feast(14'd2016, EasterMonday, 0));   // March Easter Monday
    date_q.push_back(movable_feast(14'd2024, EasterMonday, -1));  // Easter Sunday
    date_q.push_back(movable_feast(14'd1583, EasterMonday, 0));
    date_q.push_back(movable_feast(14'd9999, Ascension, 0));
    date_q.push_back(movable_feast(14'd0, EasterMonday, 0));
    date_q.push_back(movable_feast(14'd16383, WhitMonday, 0));
    queue_date(0, int'(MonJan), 0);        // day 0
    queue_date(31, 15, 16383);             // all fields at their maximum
    queue_date(1, 12, 2024);               // month past December
    queue_date(31, int'(MonMar), 2024);
    drain();

    // Sender mostly busy, receiver mostly stalled
    send_idle_pct  = 15;
    recv_stall_pct = 77;
    queue_random_dates(170);
    drain();

    // Sender mostly idle, receiver mostly ready
    send_idle_pct  = 77;
    recv_stall_pct = 15;
    queue_random_dates(170);
    drain();

    // No idling; first a long output hold while dates keep coming so the
    // pipeline fills and pushes back on its input.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_seq   = hold_req_seq + 1;
    queue_random_dates(40);
    drain();
    queue_random_dates(170);
    drain();

    repeat (DrainCycles) @(negedge clk_i);
    $display("summary: %0d dates classified, %0d of them holidays, %0d mismatches",
             results, holidays, errors);
    $display({"summary: fixed and Easter-based dates, near misses, impossible dates, ",
              "three stall mixes, long output hold"});
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== public_holiday_date_classifier.f =====
rtl/hdc_pkg.sv
rtl/hdc_split.sv
rtl/hdc_computus.sv
rtl/public_holiday_date_classifier.sv
rtl/hdc_checker.sv
test/tb_public_holiday_date_classifier.sv
